// ===== design/brm_pkg.sv =====
// Shared types and constants for the bytecode register machine execute block
package brm_pkg;

   localparam int DATA_W  = 64;
   localparam int FUNC_W  = 5;
   localparam int IDX_W   = 4;
   localparam int CNT_W   = 7;
   localparam logic [CNT_W-1:0] MUL_LAST = 7'd2;
   localparam logic [CNT_W-1:0] DIV_LAST = 7'd63;

   typedef enum logic [FUNC_W-1:0] {
      FN_NOP    = 5'd0,
      FN_MOV    = 5'd1,
      FN_MOVIMM = 5'd2,
      FN_LIT    = 5'd3,
      FN_ADD    = 5'd4,
      FN_SUB    = 5'd5,
      FN_MUL    = 5'd6,
      FN_DIV    = 5'd7,
      FN_REM    = 5'd8,
      FN_AND    = 5'd9,
      FN_OR     = 5'd10,
      FN_XOR    = 5'd11,
      FN_LSL    = 5'd12,
      FN_LSR    = 5'd13,
      FN_ASR    = 5'd14,
      FN_CMP_EQ = 5'd15,
      FN_CMP_LT = 5'd16,
      FN_CMP_GT = 5'd17,
      FN_CMP_LE = 5'd18,
      FN_CMP_GE = 5'd19,
      FN_JTRUE  = 5'd20,
      FN_JFALSE = 5'd21,
      FN_JMP    = 5'd22,
      FN_ADDR   = 5'd23
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_MUL,
      ST_DIV,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic       accept;
      logic       commit;
      logic       mul_step;
      logic [1:0] mul_idx;
      logic       div_init;
      logic       div_step;
   } cmd_type;

   typedef struct packed {
      logic is_mul;
      logic is_div;
      logic out_free;
   } status_type;

endpackage

// ===== design/brm_ctrl.sv =====
// Sequencer for the execute block: accept, execute, multi-cycle units, commit
module brm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  brm_pkg::status_type status,
   output brm_pkg::cmd_type    cmd
);

   brm_pkg::state_type          state_ff, state_in;
   logic [brm_pkg::CNT_W-1:0]   cnt_ff, cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= brm_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         brm_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = brm_pkg::ST_EXEC;
            end
         end
         brm_pkg::ST_EXEC: begin
            if (status.is_mul) begin
               state_in = brm_pkg::ST_MUL;
               cnt_in   = '0;
            end else if (status.is_div) begin
               cmd.div_init = 1'b1;
               state_in     = brm_pkg::ST_DIV;
               cnt_in       = '0;
            end else if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = brm_pkg::ST_IDLE;
            end
         end
         brm_pkg::ST_MUL: begin
            cmd.mul_step = 1'b1;
            cmd.mul_idx  = cnt_ff[1:0];
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == brm_pkg::MUL_LAST) state_in = brm_pkg::ST_WAIT;
         end
         brm_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == brm_pkg::DIV_LAST) state_in = brm_pkg::ST_WAIT;
         end
         brm_pkg::ST_WAIT: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = brm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = brm_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ===== design/brm_dpath.sv =====
// Datapath: register file, flag, program counter, multiplier, divider, result word
module brm_dpath #(
   parameter int REG_COUNT = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  brm_pkg::cmd_type    cmd,
   output brm_pkg::status_type status,
   input  logic                csr_write_enable,
   input  logic [63:0]         csr_write_data,
   input  logic [4:0]          req_func,
   input  logic                req_use_immediate,
   input  logic [3:0]          req_dest_index,
   input  logic [3:0]          req_src_index_a,
   input  logic [3:0]          req_src_index_b,
   input  logic signed [63:0]  req_immediate,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output logic                rsp_write_enable,
   output logic [3:0]          rsp_write_index,
   output logic [63:0]         rsp_write_value,
   output logic                rsp_flag_value,
   output logic [63:0]         rsp_next_pc,
   output logic                rsp_trap
);

   localparam int AW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
   localparam logic [6:0] REG_LIM = 7'(REG_COUNT);

   logic [63:0]     mem [REG_COUNT];
   logic [REG_COUNT-1:0] vld_ff;

   logic [63:0] start_ff, pc_ff, pc_in;
   logic        flag_ff, flag_in;

   logic [4:0]  func_ff;
   logic        use_imm_ff;
   logic [3:0]  dest_ff;
   logic [63:0] imm_ff, a_ff, b_ff;

   logic [63:0] acc_ff;
   logic [63:0] rem_ff, quo_ff, den_ff;
   logic        na_ff, nb_ff, bz_ff;

   logic        rsp_valid_ff, we_ff, flag_out_ff, trap_ff;
   logic [3:0]  widx_ff;
   logic [63:0] wval_ff, npc_ff;

   logic [AW-1:0] addr_a, addr_b, addr_w;
   logic [3:0]    idx_b;
   logic          in_a, in_b, in_w, req_cmp;

   logic [63:0] x, y, cy, cd, pc4, val, nxt, div_q, div_r;
   logic        wr, trap;
   logic [5:0]  sh;
   logic [31:0] m1, m2;
   logic [63:0] prod;
   logic [64:0] trial, diff;

   assign req_cmp = (req_func >= brm_pkg::FN_CMP_EQ) && (req_func <= brm_pkg::FN_CMP_GE);
   assign idx_b   = req_cmp ? req_dest_index : req_src_index_b;
   assign addr_a  = AW'(req_src_index_a);
   assign addr_b  = AW'(idx_b);
   assign addr_w  = AW'(dest_ff);
   assign in_a    = {3'b000, req_src_index_a} < REG_LIM;
   assign in_b    = {3'b000, idx_b} < REG_LIM;
   assign in_w    = {3'b000, dest_ff} < REG_LIM;

   always_ff @(posedge clock) begin
      if (cmd.commit && wr && in_w) mem[addr_w] <= val;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (cmd.commit && wr && in_w) begin
         vld_ff[addr_w] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         func_ff    <= req_func;
         use_imm_ff <= req_use_immediate;
         dest_ff    <= req_dest_index;
         imm_ff     <= req_immediate;
         a_ff       <= (in_a && vld_ff[addr_a]) ? mem[addr_a] : '0;
         b_ff       <= (in_b && vld_ff[addr_b]) ? mem[addr_b] : '0;
      end
   end

   assign x   = a_ff;
   assign y   = use_imm_ff ? imm_ff : b_ff;
   assign cd  = b_ff;
   assign cy  = use_imm_ff ? imm_ff : a_ff;
   assign pc4 = pc_ff + 64'd4;
   assign sh  = y[5:0];

   // 64x64 low product from three 32x32 partial products
   always_comb begin
      case (cmd.mul_idx)
         2'd0:    begin m1 = x[31:0];  m2 = y[31:0];  end
         2'd1:    begin m1 = x[31:0];  m2 = y[63:32]; end
         default: begin m1 = x[63:32]; m2 = y[31:0];  end
      endcase
      prod = 64'(m1) * 64'(m2);
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_step) begin
         if (cmd.mul_idx == 2'd0) acc_ff <= prod;
         else acc_ff <= acc_ff + {prod[31:0], 32'd0};
      end
   end

   // radix-2 restoring divide on magnitudes
   assign trial = {rem_ff, quo_ff[63]};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         na_ff  <= x[63];
         nb_ff  <= y[63];
         bz_ff  <= (y == 64'd0);
         rem_ff <= '0;
         quo_ff <= x[63] ? (64'd0 - x) : x;
         den_ff <= y[63] ? (64'd0 - y) : y;
      end else if (cmd.div_step) begin
         if (!diff[64]) rem_ff <= diff[63:0];
         else rem_ff <= trial[63:0];
         quo_ff <= {quo_ff[62:0], !diff[64]};
      end
   end

   assign div_q = bz_ff ? '1 : ((na_ff ^ nb_ff) ? (64'd0 - quo_ff) : quo_ff);
   assign div_r = na_ff ? (64'd0 - rem_ff) : rem_ff;

   always_comb begin
      val     = '0;
      wr      = 1'b0;
      trap    = 1'b0;
      nxt     = pc4;
      flag_in = flag_ff;
      case (func_ff)
         brm_pkg::FN_NOP:    ;
         brm_pkg::FN_MOV:    begin val = x; wr = 1'b1; end
         brm_pkg::FN_MOVIMM: begin val = imm_ff; wr = 1'b1; end
         brm_pkg::FN_LIT:    begin val = imm_ff; wr = 1'b1; nxt = pc_ff + 64'd12; end
         brm_pkg::FN_ADD:    begin val = x + y; wr = 1'b1; end
         brm_pkg::FN_SUB:    begin val = x - y; wr = 1'b1; end
         brm_pkg::FN_MUL:    begin val = acc_ff; wr = 1'b1; end
         brm_pkg::FN_DIV:    begin val = div_q; wr = 1'b1; end
         brm_pkg::FN_REM:    begin val = div_r; wr = 1'b1; end
         brm_pkg::FN_AND:    begin val = x & y; wr = 1'b1; end
         brm_pkg::FN_OR:     begin val = x | y; wr = 1'b1; end
         brm_pkg::FN_XOR:    begin val = x ^ y; wr = 1'b1; end
         brm_pkg::FN_LSL:    begin val = x << sh; wr = 1'b1; end
         brm_pkg::FN_LSR:    begin val = x >> sh; wr = 1'b1; end
         brm_pkg::FN_ASR:    begin val = 64'($signed(x) >>> sh); wr = 1'b1; end
         brm_pkg::FN_CMP_EQ: flag_in = (cd == cy);
         brm_pkg::FN_CMP_LT: flag_in = $signed(cd) < $signed(cy);
         brm_pkg::FN_CMP_GT: flag_in = $signed(cy) < $signed(cd);
         brm_pkg::FN_CMP_LE: flag_in = !($signed(cy) < $signed(cd));
         brm_pkg::FN_CMP_GE: flag_in = !($signed(cd) < $signed(cy));
         brm_pkg::FN_JTRUE:  if (flag_ff) nxt = pc4 + imm_ff;
         brm_pkg::FN_JFALSE: if (!flag_ff) nxt = pc4 + imm_ff;
         brm_pkg::FN_JMP:    nxt = pc4 + imm_ff;
         brm_pkg::FN_ADDR:   begin val = pc4 + {imm_ff[61:0], 2'b00}; wr = 1'b1; end
         default:            begin trap = 1'b1; nxt = pc_ff; end
      endcase
      if (!in_w) wr = 1'b0;
   end

   assign pc_in = nxt;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         pc_ff    <= start_ff;
         flag_ff  <= 1'b0;
      end else begin
         if (csr_write_enable) start_ff <= csr_write_data;
         if (cmd.commit) begin
            pc_ff   <= pc_in;
            flag_ff <= flag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         we_ff       <= wr;
         widx_ff     <= wr ? dest_ff : 4'd0;
         wval_ff     <= wr ? val : 64'd0;
         flag_out_ff <= flag_in;
         npc_ff      <= pc_in;
         trap_ff     <= trap;
      end
   end

   assign status.is_mul   = (func_ff == brm_pkg::FN_MUL);
   assign status.is_div   = (func_ff == brm_pkg::FN_DIV) || (func_ff == brm_pkg::FN_REM);
   assign status.out_free = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_write_enable = we_ff;
   assign rsp_write_index  = widx_ff;
   assign rsp_write_value  = wval_ff;
   assign rsp_flag_value   = flag_out_ff;
   assign rsp_next_pc      = npc_ff;
   assign rsp_trap         = trap_ff;

endmodule

// ===== design/bytecode_register_machine_execute.sv =====
// Execute block top: one decoded instruction in, one result word out.
// Mul uses three 32x32 partial products; div and rem use a radix-2 divider,
// one quotient bit a cycle. One instruction in flight; the next is taken
// the cycle after the previous one commits.
// Synchronous reset: register file reads zero, flag cleared, start address
// cleared, program counter loaded from the start address register.
module bytecode_register_machine_execute #(
   parameter int REG_COUNT = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [63:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [4:0]         req_func,
   input  logic               req_use_immediate,
   input  logic [3:0]         req_dest_index,
   input  logic [3:0]         req_src_index_a,
   input  logic [3:0]         req_src_index_b,
   input  logic signed [63:0] req_immediate,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_write_enable,
   output logic [3:0]         rsp_write_index,
   output logic [63:0]        rsp_write_value,
   output logic               rsp_flag_value,
   output logic [63:0]        rsp_next_pc,
   output logic               rsp_trap
);

   brm_pkg::cmd_type    cmd;
   brm_pkg::status_type status;

   brm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   brm_dpath #(.REG_COUNT(REG_COUNT)) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_func          (req_func),
      .req_use_immediate (req_use_immediate),
      .req_dest_index    (req_dest_index),
      .req_src_index_a   (req_src_index_a),
      .req_src_index_b   (req_src_index_b),
      .req_immediate     (req_immediate),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_write_enable  (rsp_write_enable),
      .rsp_write_index   (rsp_write_index),
      .rsp_write_value   (rsp_write_value),
      .rsp_flag_value    (rsp_flag_value),
      .rsp_next_pc       (rsp_next_pc),
      .rsp_trap          (rsp_trap)
   );

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> status.out_free)
      else $error("commit while result word blocked");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second word taken before commit");

   a_commit_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("committed result not presented");

   a_trap_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_trap && rsp_write_enable))
      else $error("trap with register write");

endmodule

// ===== test/tb_bytecode_register_machine_execute.sv =====
// Testbench for the bytecode register machine execute block
`timescale 1ns / 100ps
module tb_bytecode_register_machine_execute;

   localparam logic [4:0] FN_TRAP_LO = 5'd24;
   localparam logic [4:0] FN_TRAP_HI = 5'd31;
   localparam logic [63:0] S_MIN = 64'h8000_0000_0000_0000;
   localparam logic [63:0] S_MAX = 64'h7fff_ffff_ffff_ffff;
   localparam logic [63:0] ALL1 = '1;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct {
      logic        we;
      logic [3:0]  wi;
      logic [63:0] wv;
      logic        fl;
      logic [63:0] np;
      logic        tr;
   } exec_word_type;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [63:0] csr_write_data = '0;
   logic req_valid = 0;
   logic req_stall;
   logic [4:0] req_func = '0;
   logic req_use_immediate = 0;
   logic [3:0] req_dest_index = '0, req_src_index_a = '0, req_src_index_b = '0;
   logic signed [63:0] req_immediate = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic rsp_write_enable, rsp_flag_value, rsp_trap;
   logic [3:0] rsp_write_index;
   logic [63:0] rsp_write_value, rsp_next_pc;

   bytecode_register_machine_execute u_dut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // shadow machine state
   logic [63:0] regs [16];
   logic        cmp_flag;
   logic [63:0] pc;
   logic [63:0] start_addr;
   exec_word_type pending_words[$];
   int errors = 0, checked = 0, traps_seen = 0, divs_sent = 0;
   int hold_cycles = 0;
   int stall_mode = 0;
   int idle_count = 0;

   function automatic logic [63:0] sdivrem(logic [63:0] a, logic [63:0] b, bit want_rem);
      if (b == 0) return want_rem ? a : ALL1;
      if (a == S_MIN && b == ALL1) return want_rem ? 64'd0 : S_MIN;
      return want_rem ? 64'($signed(a) % $signed(b)) : 64'($signed(a) / $signed(b));
   endfunction

   function automatic exec_word_type execute_instr(logic [4:0] f, logic ui, logic [3:0] d,
         logic [3:0] sa, logic [3:0] sb, logic [63:0] imm);
      exec_word_type r;
      logic [63:0] pc4, x, y, cy, cd, val;
      logic [5:0] sh;
      pc4 = pc + 64'd4;
      x = regs[sa];
      y = ui ? imm : regs[sb];
      cy = ui ? imm : x;
      cd = regs[d];
      sh = y[5:0];
      val = '0;
      r.we = 0;
      r.tr = 0;
      r.np = pc4;
      case (f)
         brm_pkg::FN_NOP: ;
         brm_pkg::FN_MOV: begin val = x; r.we = 1; end
         brm_pkg::FN_MOVIMM: begin val = imm; r.we = 1; end
         brm_pkg::FN_LIT: begin val = imm; r.we = 1; r.np = pc + 64'd12; end
         brm_pkg::FN_ADD: begin val = x + y; r.we = 1; end
         brm_pkg::FN_SUB: begin val = x - y; r.we = 1; end
         brm_pkg::FN_MUL: begin val = x * y; r.we = 1; end
         brm_pkg::FN_DIV: begin val = sdivrem(x, y, 0); r.we = 1; end
         brm_pkg::FN_REM: begin val = sdivrem(x, y, 1); r.we = 1; end
         brm_pkg::FN_AND: begin val = x & y; r.we = 1; end
         brm_pkg::FN_OR: begin val = x | y; r.we = 1; end
         brm_pkg::FN_XOR: begin val = x ^ y; r.we = 1; end
         brm_pkg::FN_LSL: begin val = x << sh; r.we = 1; end
         brm_pkg::FN_LSR: begin val = x >> sh; r.we = 1; end
         brm_pkg::FN_ASR: begin val = 64'($signed(x) >>> sh); r.we = 1; end
         brm_pkg::FN_CMP_EQ: cmp_flag = (cd == cy);
         brm_pkg::FN_CMP_LT: cmp_flag = ($signed(cd) < $signed(cy));
         brm_pkg::FN_CMP_GT: cmp_flag = ($signed(cy) < $signed(cd));
         brm_pkg::FN_CMP_LE: cmp_flag = !($signed(cy) < $signed(cd));
         brm_pkg::FN_CMP_GE: cmp_flag = !($signed(cd) < $signed(cy));
         brm_pkg::FN_JTRUE: if (cmp_flag) r.np = pc4 + imm;
         brm_pkg::FN_JFALSE: if (!cmp_flag) r.np = pc4 + imm;
         brm_pkg::FN_JMP: r.np = pc4 + imm;
         brm_pkg::FN_ADDR: begin val = pc4 + (imm << 2); r.we = 1; end
         default: begin r.tr = 1; r.np = pc; end
      endcase
      if (r.we) regs[d] = val;
      pc = r.np;
      r.wi = r.we ? d : 4'd0;
      r.wv = r.we ? val : 64'd0;
      r.fl = cmp_flag;
      return r;
   endfunction

   task automatic report(string what, logic [63:0] exp_v, logic [63:0] act_v);
      errors++;
      if (errors <= 10)
         $display("mismatch word %0d %s: expected %h actual %h", checked, what, exp_v, act_v);
   endtask

   // result checking, then prediction of the word accepted at this edge
   always @(posedge clock) begin
      exec_word_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_words.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected result word %0d", checked);
         end else begin
            e = pending_words.pop_front();
            if (rsp_write_enable !== e.we) report("write_enable", e.we, rsp_write_enable);
            if (rsp_write_index !== e.wi) report("write_index", e.wi, rsp_write_index);
            if (rsp_write_value !== e.wv) report("write_value", e.wv, rsp_write_value);
            if (rsp_flag_value !== e.fl) report("flag_value", e.fl, rsp_flag_value);
            if (rsp_next_pc !== e.np) report("next_pc", e.np, rsp_next_pc);
            if (rsp_trap !== e.tr) report("trap", e.tr, rsp_trap);
            if (e.tr) traps_seen++;
         end
         checked++;
      end
      if (!reset && req_valid && !req_stall)
         pending_words.push_back(execute_instr(req_func, req_use_immediate, req_dest_index,
            req_src_index_a, req_src_index_b, req_immediate));
      if (!reset && csr_write_enable) start_addr = csr_write_data;
   end

   // receiver stall pattern, with long hold-offs on request
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1;
      end else case (stall_mode)
         0: rsp_stall <= 0;
         1: rsp_stall <= ($urandom_range(0, 99) < 30);
         default: rsp_stall <= ~rsp_stall;
      endcase
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_count <= 0;
      else
         idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d words pending", pending_words.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_instr(logic [4:0] f, logic ui, logic [3:0] d, logic [3:0] sa,
         logic [3:0] sb, logic [63:0] imm);
      req_valid <= 1;
      req_func <= f;
      req_use_immediate <= ui;
      req_dest_index <= d;
      req_src_index_a <= sa;
      req_src_index_b <= sb;
      req_immediate <= imm;
      if (f == brm_pkg::FN_DIV || f == brm_pkg::FN_REM) divs_sent++;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic idle_sender(int cycles);
      req_valid <= 0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain();
      idle_sender(1);
      while (pending_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_start_address(logic [63:0] v);
      csr_write_enable <= 1;
      csr_write_data <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   function automatic logic [63:0] rand_operand();
      case ($urandom_range(0, 9))
         0: return S_MIN;
         1: return S_MAX;
         2: return ALL1;
         3: return 64'd0;
         4: return 64'($urandom_range(0, 70));
         5: return -64'($urandom_range(1, 70));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [4:0] rand_func();
      int p;
      p = $urandom_range(0, 99);
      if (p < 4) return 5'($urandom_range(FN_TRAP_LO, FN_TRAP_HI));
      if (p < 10) return $urandom_range(0, 1) ? brm_pkg::FN_DIV : brm_pkg::FN_REM;
      if (p < 25) return $urandom_range(0, 1) ? brm_pkg::FN_LIT : brm_pkg::FN_MOVIMM;
      return 5'($urandom_range(brm_pkg::FN_NOP, brm_pkg::FN_ADDR));
   endfunction

   task automatic test_directed();
      send_instr(brm_pkg::FN_LIT, 0, 1, 0, 0, S_MIN);
      send_instr(brm_pkg::FN_MOVIMM, 0, 2, 0, 0, ALL1);
      send_instr(brm_pkg::FN_MOVIMM, 1, 4, 15, 15, S_MAX);
      send_instr(brm_pkg::FN_MOV, 0, 5, 1, 0, '0);
      send_instr(brm_pkg::FN_DIV, 0, 6, 1, 2, '0);
      send_instr(brm_pkg::FN_REM, 0, 7, 1, 2, '0);
      send_instr(brm_pkg::FN_DIV, 0, 8, 4, 3, '0);
      send_instr(brm_pkg::FN_REM, 0, 9, 4, 3, '0);
      send_instr(brm_pkg::FN_MUL, 0, 10, 4, 4, '0);
      send_instr(brm_pkg::FN_ADD, 1, 11, 4, 0, 64'd1);
      send_instr(brm_pkg::FN_SUB, 1, 12, 1, 0, 64'd1);
      send_instr(brm_pkg::FN_AND, 0, 13, 1, 2, '0);
      send_instr(brm_pkg::FN_OR, 1, 14, 3, 0, S_MIN);
      send_instr(brm_pkg::FN_XOR, 0, 15, 4, 2, '0);
      send_instr(brm_pkg::FN_LSL, 1, 0, 2, 0, 64'd63);
      send_instr(brm_pkg::FN_LSR, 1, 3, 2, 0, 64'd64);
      send_instr(brm_pkg::FN_ASR, 1, 5, 1, 0, 64'd63);
      send_instr(brm_pkg::FN_CMP_EQ, 0, 8, 8, 0, '0);
      send_instr(brm_pkg::FN_JTRUE, 0, 0, 0, 0, -64'sd8);
      send_instr(brm_pkg::FN_CMP_LT, 1, 1, 0, 0, '0);
      send_instr(brm_pkg::FN_CMP_GT, 0, 4, 1, 0, '0);
      send_instr(brm_pkg::FN_CMP_LE, 1, 4, 0, 0, S_MAX);
      send_instr(brm_pkg::FN_CMP_GE, 0, 1, 4, 0, '0);
      send_instr(brm_pkg::FN_JFALSE, 0, 0, 0, 0, S_MAX);
      send_instr(brm_pkg::FN_JMP, 0, 0, 0, 0, S_MIN);
      send_instr(brm_pkg::FN_ADDR, 0, 6, 0, 0, S_MIN);
      send_instr(FN_TRAP_LO, 1, 15, 15, 15, ALL1);
      send_instr(FN_TRAP_HI, 0, 0, 0, 0, '0);
      drain();
   endtask

   task automatic test_random(int count);
      int burst;
      burst = $urandom_range(1, 20);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) stall_mode = $urandom_range(0, 2);
         send_instr(rand_func(), 1'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
            rand_operand());
         if (--burst == 0) begin
            if ((i / 200) % 2 == 1) idle_sender($urandom_range(1, 8));
            burst = $urandom_range(1, 20);
         end
      end
      drain();
   endtask

   task automatic test_backpressure();
      hold_cycles = 200;
      for (int i = 0; i < 40; i++)
         send_instr(5'($urandom_range(brm_pkg::FN_NOP, brm_pkg::FN_ADDR)), 1'($urandom),
            4'($urandom), 4'($urandom), 4'($urandom), rand_operand());
      drain();
   endtask

   initial begin
      for (int i = 0; i < 16; i++) regs[i] = '0;
      cmp_flag = 0;
      start_addr = '0;
      pc = '0;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      write_start_address(ALL1);
      test_directed();
      test_random(600);
      write_start_address('0);
      test_backpressure();
      write_start_address({$urandom, $urandom});
      test_random(1000);
      write_start_address(S_MIN);
      drain();
      $display("checked %0d result words, %0d traps, %0d divide/remainder ops",
         checked, traps_seen, divs_sent);
      $display("covered all operations, register and immediate operands, long output stall");
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== bytecode_register_machine_execute.f =====
design/brm_pkg.sv
design/brm_ctrl.sv
design/brm_dpath.sv
design/bytecode_register_machine_execute.sv
test/tb_bytecode_register_machine_execute.sv
